### design/sltg_pkg.sv
// shared types and constants of the syslog header tagger
`timescale 1ns / 1ps
package sltg_pkg;

	localparam int MAX_RES = 3;
	localparam int Q_DEPTH = 4;

	localparam logic [3:0] TAG_VERSION  = 4'd0;
	localparam logic [3:0] TAG_TIME     = 4'd1;
	localparam logic [3:0] TAG_HOST     = 4'd2;
	localparam logic [3:0] TAG_APP      = 4'd3;
	localparam logic [3:0] TAG_PROCID   = 4'd4;
	localparam logic [3:0] TAG_MSGID    = 4'd5;
	localparam logic [3:0] TAG_SDATA    = 4'd6;
	localparam logic [3:0] TAG_CONTENT  = 4'd7;
	localparam logic [3:0] TAG_MARKER   = 4'd8;
	localparam logic [3:0] TAG_UNPARSED = 4'd9;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_5424  = 2'd1;
	localparam logic [1:0] ST_MALFORMED = 2'd2;

	localparam logic [7:0] CH_BOM0   = 8'hEF;
	localparam logic [7:0] CH_BOM1   = 8'hBB;
	localparam logic [7:0] CH_BOM2   = 8'hBF;
	localparam logic [7:0] CH_T      = 8'h54;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_OPEN   = 8'h5B;
	localparam logic [7:0] CH_CLOSE  = 8'h5D;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	typedef enum logic [13:0] {
		PH_VERSION    = 14'h0001,
		PH_TIME       = 14'h0002,
		PH_HOST       = 14'h0004,
		PH_APP        = 14'h0008,
		PH_PROC       = 14'h0010,
		PH_MSGID      = 14'h0020,
		PH_SD_START   = 14'h0040,
		PH_SD_DASH    = 14'h0080,
		PH_SD_BODY    = 14'h0100,
		PH_CONT_START = 14'h0200,
		PH_BOM1       = 14'h0400,
		PH_BOM2       = 14'h0800,
		PH_CONTENT    = 14'h1000,
		PH_UNPARSED   = 14'h2000
	} phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic [3:0] tag;
		logic       last;
		logic [1:0] status;
		logic       host_nil;
		logic       app_nil;
	} res_t;

	typedef struct packed {
		res_t [MAX_RES-1:0] item;
		logic [1:0]         cnt;
	} res_bundle_t;

	function automatic res_t mk_res(input logic [7:0] b, input logic [3:0] t);
		res_t r;
		r = '0;
		r.data = b;
		r.tag = t;
		return r;
	endfunction

endpackage

### design/sltg_parse.sv
// header parser: phase state and the tagged beats produced by one line byte
`timescale 1ns / 1ps
module sltg_parse (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            cur_byte,
	input  logic                  cur_end,
	output sltg_pkg::res_bundle_t res
);
	import sltg_pkg::*;

	phase_t     ph_q, ph_d;
	logic       quote_q, quote_d;
	logic       esc_q, esc_d;
	logic       acb_q, acb_d;
	logic       saw_t_q, saw_t_d;
	logic [1:0] flen_q, flen_d;
	logic       dash_q, dash_d;
	logic [1:0] status_q, status_d;
	logic       hnil_q, hnil_d;
	logic       anil_q, anil_d;

	logic [1:0] len_inc;
	logic       dash_inc;
	logic       is_digit;
	logic       field_nil;
	logic [3:0] hdr_tag;

	assign len_inc   = (flen_q == 2'd2) ? 2'd2 : flen_q + 2'd1;
	assign dash_inc  = dash_q | ((flen_q == 2'd0) && (cur_byte == CH_DASH));
	assign is_digit  = (cur_byte >= CH_ZERO) && (cur_byte <= CH_NINE);
	assign field_nil = (flen_q == 2'd1) && dash_q;

	always_comb begin
		case (ph_q)
			PH_HOST: hdr_tag = TAG_HOST;
			PH_APP:  hdr_tag = TAG_APP;
			PH_PROC: hdr_tag = TAG_PROCID;
			default: hdr_tag = TAG_MSGID;
		endcase
	end

	// held bytes are implied by the phase: a dash in PH_SD_DASH, EF (BB) in the bom phases
	always_comb begin
		logic [1:0] k;
		logic [1:0] st;
		k = 2'd0;
		st = ST_OK;
		res = '0;
		ph_d = ph_q;
		quote_d = quote_q;
		esc_d = esc_q;
		acb_d = acb_q;
		saw_t_d = saw_t_q;
		flen_d = flen_q;
		dash_d = dash_q;
		status_d = status_q;
		hnil_d = hnil_q;
		anil_d = anil_q;

		case (ph_q)
			PH_VERSION: begin
				if (is_digit) begin
					res.item[k] = mk_res(cur_byte, TAG_VERSION); k = k + 2'd1;
					flen_d = len_inc; dash_d = dash_inc;
				end else if (cur_byte == CH_SPACE && flen_q != 2'd0) begin
					res.item[k] = mk_res(cur_byte, TAG_MARKER); k = k + 2'd1;
					ph_d = PH_TIME; flen_d = 2'd0; dash_d = 1'b0;
				end else begin
					res.item[k] = mk_res(cur_byte, TAG_UNPARSED); k = k + 2'd1;
					status_d = ST_NOT_5424; ph_d = PH_UNPARSED;
				end
			end
			PH_TIME: begin
				if (cur_byte == CH_SPACE) begin
					if (field_nil || saw_t_q) begin
						res.item[k] = mk_res(cur_byte, TAG_MARKER); k = k + 2'd1;
						ph_d = PH_HOST; flen_d = 2'd0; dash_d = 1'b0;
					end else begin
						res.item[k] = mk_res(cur_byte, TAG_UNPARSED); k = k + 2'd1;
						status_d = ST_NOT_5424; ph_d = PH_UNPARSED;
					end
				end else begin
					res.item[k] = mk_res(cur_byte, TAG_TIME); k = k + 2'd1;
					flen_d = len_inc; dash_d = dash_inc;
					if (cur_byte == CH_T) saw_t_d = 1'b1;
				end
			end
			PH_HOST, PH_APP, PH_PROC, PH_MSGID: begin
				if (cur_byte == CH_SPACE) begin
					if (ph_q == PH_HOST) hnil_d = field_nil;
					if (ph_q == PH_APP) anil_d = field_nil;
					res.item[k] = mk_res(cur_byte, TAG_MARKER); k = k + 2'd1;
					flen_d = 2'd0; dash_d = 1'b0;
					case (ph_q)
						PH_HOST: ph_d = PH_APP;
						PH_APP:  ph_d = PH_PROC;
						PH_PROC: ph_d = PH_MSGID;
						default: ph_d = PH_SD_START;
					endcase
				end else begin
					res.item[k] = mk_res(cur_byte, hdr_tag); k = k + 2'd1;
					flen_d = len_inc; dash_d = dash_inc;
				end
			end
			PH_SD_START: begin
				if (cur_byte == CH_DASH) begin
					if (cur_end) begin
						res.item[k] = mk_res(cur_byte, TAG_SDATA); k = k + 2'd1;
						status_d = ST_MALFORMED; ph_d = PH_UNPARSED;
					end else begin
						ph_d = PH_SD_DASH;
					end
				end else if (cur_byte == CH_OPEN) begin
					res.item[k] = mk_res(cur_byte, TAG_SDATA); k = k + 2'd1;
					quote_d = 1'b0; esc_d = 1'b0; acb_d = 1'b0;
					ph_d = PH_SD_BODY;
				end else if (cur_byte == CH_BOM0) begin
					ph_d = PH_BOM1;
				end else begin
					res.item[k] = mk_res(cur_byte, TAG_CONTENT); k = k + 2'd1;
					ph_d = PH_CONTENT;
				end
			end
			PH_SD_DASH: begin
				if (cur_byte == CH_SPACE) begin
					res.item[k] = mk_res(CH_DASH, TAG_SDATA); k = k + 2'd1;
					res.item[k] = mk_res(cur_byte, TAG_MARKER); k = k + 2'd1;
					ph_d = PH_CONT_START;
				end else begin
					res.item[k] = mk_res(CH_DASH, TAG_CONTENT); k = k + 2'd1;
					res.item[k] = mk_res(cur_byte, TAG_CONTENT); k = k + 2'd1;
					ph_d = PH_CONTENT;
				end
			end
			PH_SD_BODY: begin
				if (acb_q) begin
					acb_d = 1'b0;
					if (cur_byte == CH_OPEN) begin
						res.item[k] = mk_res(cur_byte, TAG_SDATA); k = k + 2'd1;
					end else if (cur_byte == CH_SPACE) begin
						res.item[k] = mk_res(cur_byte, TAG_MARKER); k = k + 2'd1;
						ph_d = PH_CONT_START;
					end else begin
						res.item[k] = mk_res(cur_byte, TAG_UNPARSED); k = k + 2'd1;
						status_d = ST_MALFORMED; ph_d = PH_UNPARSED;
					end
				end else begin
					res.item[k] = mk_res(cur_byte, TAG_SDATA); k = k + 2'd1;
					if (esc_q) esc_d = 1'b0;
					else if (cur_byte == CH_BSLASH && quote_q) esc_d = 1'b1;
					else if (cur_byte == CH_QUOTE) quote_d = ~quote_q;
					else if (cur_byte == CH_CLOSE && !quote_q) acb_d = 1'b1;
				end
			end
			PH_CONT_START: begin
				if (cur_byte == CH_BOM0) begin
					ph_d = PH_BOM1;
				end else begin
					res.item[k] = mk_res(cur_byte, TAG_CONTENT); k = k + 2'd1;
					ph_d = PH_CONTENT;
				end
			end
			PH_BOM1: begin
				if (cur_byte == CH_BOM1) begin
					ph_d = PH_BOM2;
				end else begin
					res.item[k] = mk_res(CH_BOM0, TAG_CONTENT); k = k + 2'd1;
					res.item[k] = mk_res(cur_byte, TAG_CONTENT); k = k + 2'd1;
					ph_d = PH_CONTENT;
				end
			end
			PH_BOM2: begin
				if (cur_byte == CH_BOM2) begin
					res.item[k] = mk_res(CH_BOM0, TAG_MARKER); k = k + 2'd1;
					res.item[k] = mk_res(CH_BOM1, TAG_MARKER); k = k + 2'd1;
					res.item[k] = mk_res(cur_byte, TAG_MARKER); k = k + 2'd1;
				end else begin
					res.item[k] = mk_res(CH_BOM0, TAG_CONTENT); k = k + 2'd1;
					res.item[k] = mk_res(CH_BOM1, TAG_CONTENT); k = k + 2'd1;
					res.item[k] = mk_res(cur_byte, TAG_CONTENT); k = k + 2'd1;
				end
				ph_d = PH_CONTENT;
			end
			PH_CONTENT: begin
				res.item[k] = mk_res(cur_byte, TAG_CONTENT); k = k + 2'd1;
			end
			default: begin
				res.item[k] = mk_res(cur_byte, TAG_UNPARSED); k = k + 2'd1;
			end
		endcase

		if (cur_end) begin
			// release a partial bom as content
			case (ph_d)
				PH_BOM1: begin
					res.item[k] = mk_res(CH_BOM0, TAG_CONTENT); k = k + 2'd1;
				end
				PH_BOM2: begin
					res.item[k] = mk_res(CH_BOM0, TAG_CONTENT); k = k + 2'd1;
					res.item[k] = mk_res(CH_BOM1, TAG_CONTENT); k = k + 2'd1;
				end
				default: ;
			endcase
			case (ph_d)
				PH_VERSION, PH_TIME:                        st = ST_NOT_5424;
				PH_HOST, PH_APP, PH_PROC, PH_MSGID, PH_SD_BODY: st = ST_MALFORMED;
				PH_UNPARSED:                                st = status_d;
				default:                                    st = ST_OK;
			endcase
			res.item[k - 2'd1].last = 1'b1;
			res.item[k - 2'd1].status = st;
			res.item[k - 2'd1].host_nil = hnil_d;
			res.item[k - 2'd1].app_nil = anil_d;
			ph_d = PH_VERSION;
			quote_d = 1'b0; esc_d = 1'b0; acb_d = 1'b0; saw_t_d = 1'b0;
			flen_d = 2'd0; dash_d = 1'b0;
			status_d = ST_OK; hnil_d = 1'b0; anil_d = 1'b0;
		end
		res.cnt = k;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_VERSION;
			quote_q <= 1'b0;
			esc_q <= 1'b0;
			acb_q <= 1'b0;
			saw_t_q <= 1'b0;
			flen_q <= 2'd0;
			dash_q <= 1'b0;
			status_q <= ST_OK;
			hnil_q <= 1'b0;
			anil_q <= 1'b0;
		end else if (step) begin
			ph_q <= ph_d;
			quote_q <= quote_d;
			esc_q <= esc_d;
			acb_q <= acb_d;
			saw_t_q <= saw_t_d;
			flen_q <= flen_d;
			dash_q <= dash_d;
			status_q <= status_d;
			hnil_q <= hnil_d;
			anil_q <= anil_d;
		end
	end

endmodule

### design/sltg_outq.sv
// result queue: takes up to three tagged beats a cycle, gives one a cycle while ready is high
`timescale 1ns / 1ps
module sltg_outq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  sltg_pkg::res_bundle_t bun,
	output logic                  room,
	output logic                  valid,
	input  logic                  ready,
	output sltg_pkg::res_t        head
);
	import sltg_pkg::*;

	localparam int PW = $clog2(Q_DEPTH);
	localparam int CW = $clog2(Q_DEPTH + 1);

	res_t            mem_q [Q_DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            pop;
	logic [CW-1:0]   n_push;

	assign valid  = (count_q != '0);
	assign head   = mem_q[rd_ptr_q];
	assign pop    = valid && ready;
	assign n_push = push ? CW'(bun.cnt) : '0;
	// room for the largest burst one byte can produce, not counting this cycle's pop
	assign room   = (count_q <= CW'(Q_DEPTH - MAX_RES));

	always_ff @(posedge clk) begin
		if (push) begin
			for (int i = 0; i < MAX_RES; i++) begin
				if (i < int'(bun.cnt)) mem_q[wr_ptr_q + PW'(i)] <= bun.item[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(n_push);
			if (pop) rd_ptr_q <= rd_ptr_q + PW'(1);
			count_q <= count_q + n_push - (pop ? CW'(1) : CW'(0));
		end
	end

endmodule

### design/syslog_rfc5424_header_tagger_unit.sv
// top level of the syslog header tagger
`timescale 1ns / 1ps
// Tags each byte of a syslog line (the part after <PRIO>) with its header field.
// Line channel: line_valid/line_ready carry one byte per beat, line_end on the
// final byte of the line. Tag channel: tag_valid/tag_ready carry one tagged byte
// per beat, in original order, out_last on the line's final beat, where
// parse_status, host_is_nil and app_is_nil hold the verdict for the line.
// A line byte is captured in an input register, then the parser writes
// its zero to three tagged beats into a four-entry result queue, which
// drives the tag port. A dash before structured data and bom bytes are
// held back until the next byte decides them.
// Throughput is one byte per cycle while each byte gives at most one beat
// and tag_ready stays high; the tag port drains one beat per cycle, so bytes
// that release held beats hold up the line port. The queue accepts a byte
// only with room for three beats.
// Reset clears the parser to the version field and empties the queue.
// When the receiver stalls the queue fills and line_ready drops; nothing is lost.
module syslog_rfc5424_header_tagger_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       line_valid,
	output logic       line_ready,
	input  logic [7:0] line_byte,
	input  logic       line_end,
	output logic       tag_valid,
	input  logic       tag_ready,
	output logic [7:0] out_byte,
	output logic [3:0] field_tag,
	output logic       out_last,
	output logic [1:0] parse_status,
	output logic       host_is_nil,
	output logic       app_is_nil
);
	import sltg_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        end_s1;
	logic        room;
	logic        advance;
	res_bundle_t bun;
	res_t        head;

	assign advance    = valid_s1 && room;
	assign line_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (line_valid && line_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (line_valid && line_ready) begin
			byte_s1 <= line_byte;
			end_s1 <= line_end;
		end
	end

	sltg_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.cur_byte (byte_s1),
		.cur_end  (end_s1),
		.res      (bun)
	);

	sltg_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (advance),
		.bun    (bun),
		.room   (room),
		.valid  (tag_valid),
		.ready  (tag_ready),
		.head   (head)
	);

	assign out_byte     = head.data;
	assign field_tag    = head.tag;
	assign out_last     = head.last;
	assign parse_status = head.status;
	assign host_is_nil  = head.host_nil;
	assign app_is_nil   = head.app_nil;

endmodule

### design/sltg_checker.sv
// port checks of the syslog header tagger and their bind
`timescale 1ns / 1ps
module sltg_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       line_valid,
	input logic       line_ready,
	input logic [7:0] line_byte,
	input logic       line_end,
	input logic       tag_valid,
	input logic       tag_ready,
	input logic [7:0] out_byte,
	input logic [3:0] field_tag,
	input logic       out_last,
	input logic [1:0] parse_status,
	input logic       host_is_nil,
	input logic       app_is_nil
);
	import sltg_pkg::*;

	// a waiting line beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		line_valid && !line_ready |=> line_valid && $stable(line_byte) && $stable(line_end))
		else $error("line beat changed while waiting");

	// a stalled beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		tag_valid && !tag_ready |=> tag_valid && $stable(out_byte) && $stable(field_tag)
		&& $stable(out_last))
		else $error("tag beat changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		tag_valid |-> field_tag <= TAG_UNPARSED && parse_status != 2'd3)
		else $error("tag or status code out of range");

	// verdict fields only on the line's last beat
	assert property (@(posedge clk) disable iff (!arst_n)
		tag_valid && !out_last |-> parse_status == ST_OK && !host_is_nil && !app_is_nil)
		else $error("verdict shown on a beat that is not last");

	// a not-5424 line can never have passed the hostname field
	assert property (@(posedge clk) disable iff (!arst_n)
		tag_valid && out_last && parse_status == ST_NOT_5424 |-> !host_is_nil && !app_is_nil)
		else $error("nil flags on a line rejected before the hostname");

endmodule

bind syslog_rfc5424_header_tagger_unit sltg_checker u_sltg_checker (.*);
